FILE: rtl/sfp_pkg.sv
// Shared types, constants and the CRC-8 step function for the sensor frame parser.
// Used by sfp_front, sfp_queue, sfp_back and sensor_frame_parser_crc8.
// No dependencies.
package sfp_pkg;

    // CRC-8, polynomial x^8 + x^4 + x^3 + x^2 + 1, MSB first
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // frame layout codes
    localparam logic [7:0] HDR_OK      = 8'h01;
    localparam logic [7:0] TYPE_SENSOR = 8'hAA;
    localparam logic [7:0] TYPE_PARAM  = 8'hBB;

    // minimum frame lengths in bytes
    localparam logic [3:0] LEN_MIN    = 4'd2;
    localparam logic [3:0] LEN_SENSOR = 4'd8;
    localparam logic [3:0] LEN_PARAM  = 4'd7;

    // byte positions inside a frame
    localparam logic [3:0] POS_HDR     = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_ID      = 4'd2;
    localparam logic [3:0] POS_PL_LO   = 4'd3;
    localparam logic [3:0] POS_PL_HI   = 4'd6;
    localparam logic [3:0] POS_PCHECK  = 4'd6;
    localparam logic [3:0] POS_SCHECK  = 4'd7;
    localparam logic [3:0] COUNT_MAX   = 4'd15;

    // default depth of the record queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // result status codes
    typedef enum logic [2:0] {
        ST_SENSOR_OK  = 3'd0,
        ST_PARAM_OK   = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_CRC_ERROR  = 3'd3,
        ST_UNKNOWN    = 3'd4,
        ST_TOO_SHORT  = 3'd5
    } status_t;

    // one classified frame, handed from front to back
    typedef struct packed {
        status_t     status;
        logic [7:0]  id;
        logic [31:0] payload;
        logic [7:0]  check;
        logic [7:0]  crc;
    } frame_rec_t;

    // queue handshake between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    // one byte of CRC-8, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00)
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sfp_front.sv
// Front end: takes frame bytes, runs the CRC, captures layout fields and
// classifies each frame at its last byte. Depends on sfp_pkg.
module sfp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               end_of_frame,
    input  logic               accept,
    output logic               push,
    output sfp_pkg::frame_rec_t push_rec
);

    logic [7:0]  crc_reg,     crc_next;
    logic [3:0]  count_reg,   count_next;
    logic [7:0]  header_reg,  header_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  id_reg,      id_next;
    logic [31:0] payload_reg, payload_next;
    logic [7:0]  scheck_reg,  scheck_next;
    logic [7:0]  pcheck_reg,  pcheck_next;
    sfp_pkg::status_t status_c;

    // per-byte update of the frame state
    always_comb
    begin
        crc_next     = sfp_pkg::crc8_byte(crc_reg, data_byte);
        header_next  = header_reg;
        type_next    = type_reg;
        id_next      = id_reg;
        payload_next = payload_reg;
        scheck_next  = scheck_reg;
        pcheck_next  = pcheck_reg;
        if (count_reg == sfp_pkg::POS_HDR)
        begin
            header_next = data_byte;
        end
        else if (count_reg == sfp_pkg::POS_TYPE)
        begin
            type_next = data_byte;
        end
        else if (count_reg == sfp_pkg::POS_ID)
        begin
            id_next = data_byte;
        end
        if (count_reg >= sfp_pkg::POS_PL_LO && count_reg <= sfp_pkg::POS_PL_HI)
        begin
            payload_next = {payload_reg[23:0], data_byte};
        end
        if (count_reg == sfp_pkg::POS_PCHECK)
        begin
            pcheck_next = data_byte;
        end
        if (count_reg == sfp_pkg::POS_SCHECK)
        begin
            scheck_next = data_byte;
        end
        count_next = (count_reg == sfp_pkg::COUNT_MAX) ? count_reg : count_reg + 4'd1;
    end

    // classification: header, then CRC, then length and type
    always_comb
    begin
        if (header_next != sfp_pkg::HDR_OK)
        begin
            status_c = sfp_pkg::ST_BAD_HEADER;
        end
        else if (crc_next != 8'h00)
        begin
            status_c = sfp_pkg::ST_CRC_ERROR;
        end
        else if (count_next < sfp_pkg::LEN_MIN)
        begin
            status_c = sfp_pkg::ST_TOO_SHORT;
        end
        else if (type_next == sfp_pkg::TYPE_SENSOR)
        begin
            status_c = (count_next < sfp_pkg::LEN_SENSOR) ? sfp_pkg::ST_TOO_SHORT
                                                          : sfp_pkg::ST_SENSOR_OK;
        end
        else if (type_next == sfp_pkg::TYPE_PARAM)
        begin
            status_c = (count_next < sfp_pkg::LEN_PARAM) ? sfp_pkg::ST_TOO_SHORT
                                                         : sfp_pkg::ST_PARAM_OK;
        end
        else
        begin
            status_c = sfp_pkg::ST_UNKNOWN;
        end
    end

    // record for the queue
    always_comb
    begin
        push_rec.status  = status_c;
        push_rec.id      = id_next;
        push_rec.payload = payload_next;
        push_rec.check   = (status_c == sfp_pkg::ST_PARAM_OK) ? pcheck_next : scheck_next;
        push_rec.crc     = crc_next;
    end

    assign push = accept & end_of_frame;

    // frame state; cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= '0;
            count_reg   <= '0;
            header_reg  <= '0;
            type_reg    <= '0;
            id_reg      <= '0;
            payload_reg <= '0;
            scheck_reg  <= '0;
            pcheck_reg  <= '0;
        end
        else if (accept)
        begin
            if (end_of_frame)
            begin
                crc_reg     <= '0;
                count_reg   <= '0;
                header_reg  <= '0;
                type_reg    <= '0;
                id_reg      <= '0;
                payload_reg <= '0;
                scheck_reg  <= '0;
                pcheck_reg  <= '0;
            end
            else
            begin
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                header_reg  <= header_next;
                type_reg    <= type_next;
                id_reg      <= id_next;
                payload_reg <= payload_next;
                scheck_reg  <= scheck_next;
                pcheck_reg  <= pcheck_next;
            end
        end
    end

endmodule

FILE: rtl/sfp_queue.sv
// Short record queue between the front end and the back end.
// Depends on sfp_pkg for the record type.
module sfp_queue
#(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfp_pkg::frame_rec_t  push_rec,
    input  logic                 pop,
    output sfp_pkg::frame_rec_t  pop_rec,
    output sfp_pkg::queue_flags_t flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfp_pkg::frame_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign pop_rec     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // checks on queue bookkeeping
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !flags.full)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !flags.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule

FILE: rtl/sfp_back.sv
// Back end: formats one queued frame record into the result register and
// holds it until the receiver takes it. Depends on sfp_pkg.
module sfp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    input  sfp_pkg::frame_rec_t rec,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [2:0]          status,
    output logic [7:0]          record_id,
    output logic [31:0]         sensor_word,
    output logic [7:0]          name_first,
    output logic [7:0]          name_second,
    output logic [7:0]          param_value,
    output logic [7:0]          check_byte,
    output logic [7:0]          crc_remainder
);

    logic        valid_reg, valid_next;
    logic [2:0]  status_reg,  status_next;
    logic [7:0]  id_reg,      id_next;
    logic [31:0] sword_reg,   sword_next;
    logic [7:0]  name1_reg,   name1_next;
    logic [7:0]  name2_reg,   name2_next;
    logic [7:0]  value_reg,   value_next;
    logic [7:0]  check_reg,   check_next;
    logic [7:0]  crc_reg,     crc_next;

    // load a new result when the register is empty or being taken
    assign pop = rec_valid & (~valid_reg | ~out_stall);

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    // field selection by status; unused fields read zero
    always_comb
    begin
        status_next = rec.status;
        id_next     = '0;
        sword_next  = '0;
        name1_next  = '0;
        name2_next  = '0;
        value_next  = '0;
        check_next  = '0;
        crc_next    = rec.crc;
        case (rec.status)
            sfp_pkg::ST_SENSOR_OK:
            begin
                id_next    = rec.id;
                sword_next = rec.payload;
                check_next = rec.check;
            end
            sfp_pkg::ST_PARAM_OK:
            begin
                id_next    = rec.id;
                name1_next = rec.payload[31:24];
                name2_next = rec.payload[23:16];
                value_next = rec.payload[15:8];
                check_next = rec.check;
            end
            default:
            begin
                id_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload, loaded only on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            sword_reg  <= sword_next;
            name1_reg  <= name1_next;
            name2_reg  <= name2_next;
            value_reg  <= value_next;
            check_reg  <= check_next;
            crc_reg    <= crc_next;
        end
    end

    assign out_valid     = valid_reg;
    assign status        = status_reg;
    assign record_id     = id_reg;
    assign sensor_word   = sword_reg;
    assign name_first    = name1_reg;
    assign name_second   = name2_reg;
    assign param_value   = value_reg;
    assign check_byte    = check_reg;
    assign crc_remainder = crc_reg;

endmodule

FILE: rtl/sensor_frame_parser_crc8.sv
// Sensor frame parser with CRC-8 check (poly 0x1D, init 0, MSB first).
// Byte input channel: data_byte/end_of_frame with in_valid/in_stall.
// Result channel: status and frame fields with out_valid/out_stall.
//
// One byte is accepted per cycle while in_stall is low. The byte marked
// end_of_frame closes the frame; its classified record enters a short queue
// when that byte is taken and moves on from there into the result register,
// which raises out_valid. Sustained rate is one byte per cycle while
// in_stall is low and one result per frame; the limit is the CRC-8 byte
// step, computed combinationally in the front end.
// While the receiver stalls, the result register holds its value and the
// queue keeps absorbing frames; once the queue (QUEUE_DEPTH records) is
// full, in_stall rises and the front end waits.
// Reset (rst_n low, asynchronous) clears the CRC, byte count and frame
// fields, empties the queue and drops out_valid.
// Depends on sfp_pkg, sfp_front, sfp_queue, sfp_back.
module sensor_frame_parser_crc8
#(
    parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  record_id,
    output logic [31:0] sensor_word,
    output logic [7:0]  name_first,
    output logic [7:0]  name_second,
    output logic [7:0]  param_value,
    output logic [7:0]  check_byte,
    output logic [7:0]  crc_remainder
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    sfp_pkg::frame_rec_t   push_rec;
    sfp_pkg::frame_rec_t   pop_rec;
    sfp_pkg::queue_flags_t flags;

    // input request handshake
    assign in_stall = flags.full;
    assign accept   = in_valid & ~flags.full;

    sfp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .accept       (accept),
        .push         (push),
        .push_rec     (push_rec)
    );

    sfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .flags    (flags)
    );

    sfp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (~flags.empty),
        .rec           (pop_rec),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .record_id     (record_id),
        .sensor_word   (sensor_word),
        .name_first    (name_first),
        .name_second   (name_second),
        .param_value   (param_value),
        .check_byte    (check_byte),
        .crc_remainder (crc_remainder)
    );

endmodule

FILE: bench/sensor_frame_parser_crc8_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sensor_frame_parser_crc8: byte-stream frames in, one
// classified record per frame out, checked against an in-bench CRC-8 frame predictor.
// Depends on sfp_pkg and the sensor_frame_parser_crc8 RTL.

// CRC-8 byte step, poly 0x1D, MSB first
function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8)
    begin
        c = c[7] ? ({c[6:0], 1'b0} ^ 8'h1D) : {c[6:0], 1'b0};
    end
    return c;
endfunction

typedef struct {
    sfp_pkg::status_t status;
    logic [7:0]  record_id;
    logic [31:0] sensor_word;
    logic [7:0]  name_first;
    logic [7:0]  name_second;
    logic [7:0]  param_value;
    logic [7:0]  check_byte;
    logic [7:0]  crc_remainder;
} frame_record_t;

// Tracks frame state per accepted byte request and checks each record in order
class frame_scoreboard;
    frame_record_t records_due[$];
    int          mismatches;
    logic [7:0]  crc_acc;
    logic [3:0]  count;
    logic [7:0]  hdr;
    logic [7:0]  typ;
    logic [7:0]  id;
    logic [31:0] shift;
    logic [7:0]  sensor_chk;
    logic [7:0]  param_chk;

    function new();
        mismatches = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        crc_acc    = 8'h00;
        count      = 4'd0;
        hdr        = 8'h00;
        typ        = 8'h00;
        id         = 8'h00;
        shift      = 32'h0;
        sensor_chk = 8'h00;
        param_chk  = 8'h00;
    endfunction

    // one accepted byte request; closes a frame on end_of_frame
    function void note_byte(input logic [7:0] b, input bit eof);
        frame_record_t rec;
        logic [3:0]    pos;
        pos = count;
        crc_acc = crc8_next(crc_acc, b);
        case (pos)
            sfp_pkg::POS_HDR:  hdr = b;
            sfp_pkg::POS_TYPE: typ = b;
            sfp_pkg::POS_ID:   id = b;
            default:  ;
        endcase
        if (pos >= sfp_pkg::POS_PL_LO && pos <= sfp_pkg::POS_PL_HI)
        begin
            shift = {shift[23:0], b};
        end
        if (pos == sfp_pkg::POS_PCHECK)
        begin
            param_chk = b;
        end
        if (pos == sfp_pkg::POS_SCHECK)
        begin
            sensor_chk = b;
        end
        if (count != sfp_pkg::COUNT_MAX)
        begin
            count = count + 4'd1;
        end
        if (!eof)
        begin
            return;
        end

        // header first, then CRC, then length and type
        if (hdr != sfp_pkg::HDR_OK)
            rec.status = sfp_pkg::ST_BAD_HEADER;
        else if (crc_acc != 8'h00)
            rec.status = sfp_pkg::ST_CRC_ERROR;
        else if (count < sfp_pkg::LEN_MIN)
            rec.status = sfp_pkg::ST_TOO_SHORT;
        else if (typ == sfp_pkg::TYPE_SENSOR)
            rec.status = (count < sfp_pkg::LEN_SENSOR) ? sfp_pkg::ST_TOO_SHORT
                                                       : sfp_pkg::ST_SENSOR_OK;
        else if (typ == sfp_pkg::TYPE_PARAM)
            rec.status = (count < sfp_pkg::LEN_PARAM) ? sfp_pkg::ST_TOO_SHORT
                                                      : sfp_pkg::ST_PARAM_OK;
        else
            rec.status = sfp_pkg::ST_UNKNOWN;

        rec.record_id     = 8'h00;
        rec.sensor_word   = 32'h0;
        rec.name_first    = 8'h00;
        rec.name_second   = 8'h00;
        rec.param_value   = 8'h00;
        rec.check_byte    = 8'h00;
        rec.crc_remainder = crc_acc;
        if (rec.status == sfp_pkg::ST_SENSOR_OK)
        begin
            rec.record_id   = id;
            rec.sensor_word = shift;
            rec.check_byte  = sensor_chk;
        end
        else if (rec.status == sfp_pkg::ST_PARAM_OK)
        begin
            rec.record_id   = id;
            rec.name_first  = shift[31:24];
            rec.name_second = shift[23:16];
            rec.param_value = shift[15:8];
            rec.check_byte  = param_chk;
        end
        records_due.insert(records_due.size(), rec);
        clear_frame();
    endfunction

    function void field_check(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: record %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    function void check_record(input logic [2:0] st, input logic [7:0] rid,
                               input logic [31:0] word, input logic [7:0] n1,
                               input logic [7:0] n2, input logic [7:0] val,
                               input logic [7:0] chk, input logic [7:0] crc);
        frame_record_t want;
        if (records_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: record with no frame pending, status %0d", $time, st);
            return;
        end
        want = records_due.pop_front();
        field_check("status", 32'(want.status), 32'(st));
        field_check("record_id", 32'(want.record_id), 32'(rid));
        field_check("sensor_word", want.sensor_word, word);
        field_check("name_first", 32'(want.name_first), 32'(n1));
        field_check("name_second", 32'(want.name_second), 32'(n2));
        field_check("param_value", 32'(want.param_value), 32'(val));
        field_check("check_byte", 32'(want.check_byte), 32'(chk));
        field_check("crc_remainder", 32'(want.crc_remainder), 32'(crc));
    endfunction
endclass

module sensor_frame_parser_crc8_tb;

    localparam int ITEMS    = 1650;
    localparam int MAX_LATE = 20;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic        end_of_frame = 1'b0;
    logic        out_stall    = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [7:0]  record_id;
    logic [31:0] sensor_word;
    logic [7:0]  name_first;
    logic [7:0]  name_second;
    logic [7:0]  param_value;
    logic [7:0]  check_byte;
    logic [7:0]  crc_remainder;

    frame_scoreboard sb = new();

    int         stall_left = 0;
    int         free_left  = 0;
    int         stall_pick;
    int         bytes_sent = 0;
    bit         quiet      = 1'b0;
    logic [7:0] frame_buf[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sensor_frame_parser_crc8 uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_frame  (end_of_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .record_id     (record_id),
        .sensor_word   (sensor_word),
        .name_first    (name_first),
        .name_second   (name_second),
        .param_value   (param_value),
        .check_byte    (check_byte),
        .crc_remainder (crc_remainder)
    );

    // receiver stall: short bursts, a few long ones, and stall-free stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left <= free_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 10)
                free_left <= $urandom_range(20, 80);
            else if (stall_pick < 14)
                stall_left <= $urandom_range(10, 40);
            else if (stall_pick < 50)
                stall_left <= $urandom_range(1, 3);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_record(status, record_id, sensor_word, name_first, name_second,
                            param_value, check_byte, crc_remainder);
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte request, held until accepted
    task automatic send_byte(input logic [7:0] b, input bit eof);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    // sends frame_buf, optionally closing it with its CRC and flipping one bit
    task automatic send_frame(input bit fix_crc, input bit corrupt);
        logic [7:0] acc;
        int         k;
        if (fix_crc)
        begin
            acc = 8'h00;
            foreach (frame_buf[i])
                acc = crc8_next(acc, frame_buf[i]);
            frame_buf.insert(frame_buf.size(), acc);
        end
        if (corrupt)
        begin
            k = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < frame_buf.size(); k++)
            send_byte(frame_buf[k], k == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    // header, type, then random bytes up to n bytes before the CRC
    task automatic fill_frame(input logic [7:0] h, input logic [7:0] t, input int n);
        frame_buf.delete();
        frame_buf.insert(frame_buf.size(), h);
        if (n > 1)
            frame_buf.insert(frame_buf.size(), t);
        while (frame_buf.size() < n)
            frame_buf.insert(frame_buf.size(), 8'($urandom));
    endtask

    // sender holds off until every pending record is out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.records_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         r;
        int         n;
        logic [7:0] h;
        logic [7:0] t;
        bit         drained_mid;

        drained_mid = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each status, field extremes
        frame_buf = '{sfp_pkg::HDR_OK, sfp_pkg::TYPE_SENSOR,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b1, 1'b0);
        frame_buf = '{sfp_pkg::HDR_OK, sfp_pkg::TYPE_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_frame(1'b1, 1'b0);
        frame_buf = '{8'h00};
        send_frame(1'b0, 1'b0);
        frame_buf = '{sfp_pkg::HDR_OK, sfp_pkg::TYPE_SENSOR};
        send_frame(1'b1, 1'b0);
        frame_buf = '{sfp_pkg::HDR_OK, 8'h55};
        send_frame(1'b1, 1'b0);
        frame_buf = '{sfp_pkg::HDR_OK, sfp_pkg::TYPE_PARAM};
        send_frame(1'b0, 1'b0);
        drain_results();

        // random: mostly well-formed frames, plus broken ones and noise
        while (bytes_sent < ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                quiet = !quiet;
            t = $urandom_range(0, 1) ? sfp_pkg::TYPE_SENSOR : sfp_pkg::TYPE_PARAM;
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : 7;
                fill_frame(sfp_pkg::HDR_OK, sfp_pkg::TYPE_SENSOR, n);
                send_frame(1'b1, 1'b0);
            end
            else if (r < 62)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11) : 6;
                fill_frame(sfp_pkg::HDR_OK, sfp_pkg::TYPE_PARAM, n);
                send_frame(1'b1, 1'b0);
            end
            else if (r < 70)
            begin
                // too short for its type, CRC intact
                n = (t == sfp_pkg::TYPE_SENSOR) ? $urandom_range(1, 6) : $urandom_range(1, 5);
                fill_frame(sfp_pkg::HDR_OK, t, n);
                send_frame(1'b1, 1'b0);
            end
            else if (r < 77)
            begin
                h = 8'($urandom);
                if (h == sfp_pkg::TYPE_SENSOR || h == sfp_pkg::TYPE_PARAM)
                    h = 8'h00;
                fill_frame(sfp_pkg::HDR_OK, h, $urandom_range(2, 9));
                send_frame(1'b1, 1'b0);
            end
            else if (r < 84)
            begin
                fill_frame(sfp_pkg::HDR_OK, t, (t == sfp_pkg::TYPE_SENSOR) ? 7 : 6);
                send_frame(1'b1, 1'b1);
            end
            else if (r < 89)
            begin
                h = 8'($urandom);
                if (h == sfp_pkg::HDR_OK)
                    h = 8'h00;
                fill_frame(h, t, $urandom_range(1, 9));
                send_frame(1'($urandom_range(0, 1)), 1'b0);
            end
            else if (r < 94)
            begin
                // raw bytes with a random end mark
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
            begin
                // long frame, byte count saturates
                fill_frame(sfp_pkg::HDR_OK, t, $urandom_range(15, 21));
                send_frame(1'b1, 1'b0);
            end
            if (!drained_mid && bytes_sent >= ITEMS / 2)
            begin
                drained_mid = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (MAX_LATE) @(posedge clk);
        if (sb.mismatches == 0 && sb.records_due.size() == 0)
            $display("** sensor_frame_parser_crc8: PASSED **");
        else
            $display("** sensor_frame_parser_crc8: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("** sensor_frame_parser_crc8: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sfp_pkg.sv
rtl/sfp_front.sv
rtl/sfp_queue.sv
rtl/sfp_back.sv
rtl/sensor_frame_parser_crc8.sv
bench/sensor_frame_parser_crc8_tb.sv
